// ===== sv/mesh_edge_adjacency_matcher_macros.svh =====
// Assertion macros shared by the edge adjacency matcher
`ifndef MESH_EDGE_ADJACENCY_MATCHER_MACROS_SVH
`define MESH_EDGE_ADJACENCY_MATCHER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MEA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("edge adjacency matcher check failed");

// Next-cycle implication, checked outside reset
`define MEA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("edge adjacency matcher check failed");

`endif

// ===== sv/mea_pkg.sv =====
// Shared types and constants of the edge adjacency matcher
package mea_pkg;

    localparam int KIND_W   = 2;
    localparam int V0_W     = 21;
    localparam int V_W      = 20;
    localparam int TRI_W    = 14;
    localparam int LINK_W   = 17;
    localparam int STATUS_W = 3;
    localparam int OPEN_W   = 16;

    localparam int PROBE_LIMIT = 32;
    localparam int PROBE_W     = $clog2(PROBE_LIMIT);
    localparam int HASH_W      = 32;
    localparam int HASH_CNT_W  = $clog2(HASH_W);

    localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [TRI_W-1:0]  TRI_SAT  = {TRI_W{1'b1}};
    localparam logic [OPEN_W-1:0] OPEN_SAT = {OPEN_W{1'b1}};
    localparam logic [LINK_W-1:0] LINK_NONE = {LINK_W{1'b1}};

    // Vertex pair of each edge: (v0,v1), (v2,v0), (v1,v2)
    localparam logic [1:0] EDGE_ENDS [3][2] = '{'{2'd0, 2'd1}, '{2'd2, 2'd0}, '{2'd1, 2'd2}};

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 2'd0,
        KIND_TRI    = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_TRIPLE   = 3'd1,
        ST_FULL     = 3'd2,
        ST_TOO_MANY = 3'd3,
        ST_IGNORED  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_RCLEAR,
        S_SCLEAR,
        S_IDLE,
        S_DISPATCH,
        S_EDGE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    clr_step;
        logic    clr_counters;
        logic    tri_begin;
        logic    set_ignored;
        logic    set_fault;
        t_status fault_code;
        logic    hash_start;
        logic    probe_next;
        logic    wr_new;
        logic    wr_pair;
        logic    edge_next;
        logic    finish_rep;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        logic is_start;
        logic is_tri;
        logic is_finish;
        logic faulted;
        logic tri_full;
        logic skip;
        logic clr_last;
        logic hash_done;
        logic rd_free;
        logic rd_match;
        logic rd_done;
        logic probe_last;
        logic edge_last;
        logic out_free;
    } t_st;

endpackage

// ===== sv/mesh_edge_adjacency_matcher.sv =====
// Top level of the triangle mesh edge adjacency matcher
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------------
//  request  | i_in_valid / o_in_ready    | i_kind, i_v0, i_v1, i_v2
//  result   | o_out_valid / i_out_ready  | o_tri_index, o_link0..2, o_status,
//           |                            | o_watertight, o_open_edges
//
// A triangle hashes each of its edges and probes the table linearly from that hash; the edge
// hash runs on one shared 32x32 multiplier over three passes, and a capacity that is not
// a power of two adds 32 remainder steps per edge.
// After reset and on every start the table is cleared, one entry a cycle, with
// o_in_ready low. A stalled result holds in the output register while the next
// request is processed up to its own result.
`include "mesh_edge_adjacency_matcher_macros.svh"

module mesh_edge_adjacency_matcher #(
    parameter int MAX_TRIANGLES = 16384,
    parameter int EDGE_CAPACITY = 32768,
    parameter int VERTEX_BITS   = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mea_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [mea_pkg::V0_W-1:0]   i_v0,
    input  logic [mea_pkg::V_W-1:0]           i_v1,
    input  logic [mea_pkg::V_W-1:0]           i_v2,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mea_pkg::TRI_W-1:0]         o_tri_index,
    output logic signed [mea_pkg::LINK_W-1:0] o_link0,
    output logic signed [mea_pkg::LINK_W-1:0] o_link1,
    output logic signed [mea_pkg::LINK_W-1:0] o_link2,
    output logic [mea_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_watertight,
    output logic [mea_pkg::OPEN_W-1:0]        o_open_edges
);

    mea_pkg::t_cmd cmd;
    mea_pkg::t_st  st;

    // Sequencer
    mea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // Datapath
    mea_dp #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .EDGE_CAPACITY (EDGE_CAPACITY),
        .VERTEX_BITS   (VERTEX_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_kind       (i_kind),
        .i_v0         (i_v0),
        .i_v1         (i_v1),
        .i_v2         (i_v2),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_tri_index  (o_tri_index),
        .o_link0      (o_link0),
        .o_link1      (o_link1),
        .o_link2      (o_link2),
        .o_status     (o_status),
        .o_watertight (o_watertight),
        .o_open_edges (o_open_edges)
    );

    // A watertight report carries no fault and no open edge
    `MEA_ASSERT_IMP(a_watertight_clean, o_out_valid && o_watertight, o_status == mea_pkg::ST_OK && o_open_edges == '0)
    // A faulting or ignored result carries no partner slot
    `MEA_ASSERT_IMP(a_fault_no_links, o_out_valid && o_status != mea_pkg::ST_OK, o_link0 == -17'sd1 && o_link1 == -17'sd1 && o_link2 == -17'sd1)
    // One request at a time: ready drops after each accepted request
    `MEA_ASSERT_NXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready)

endmodule

// ===== sv/mea_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module mea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mea_ctrl.sv =====
// Sequencer of the edge adjacency matcher: clearing, hashing, probing, reporting
module mea_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mea_pkg::t_st  i_st,
    output mea_pkg::t_cmd o_cmd
);

    mea_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mea_pkg::S_RCLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.fault_code = mea_pkg::ST_OK;
        o_in_ready       = 1'b0;
        unique case (r_state)
            mea_pkg::S_RCLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) begin
                    n_state = mea_pkg::S_IDLE;
                end
            end
            mea_pkg::S_SCLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) begin
                    n_state = mea_pkg::S_EMIT;
                end
            end
            mea_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mea_pkg::S_DISPATCH;
                end
            end
            mea_pkg::S_DISPATCH: begin
                if (i_st.is_start) begin
                    o_cmd.clr_counters = 1'b1;
                    n_state            = mea_pkg::S_SCLEAR;
                end else if (i_st.is_finish) begin
                    o_cmd.finish_rep = 1'b1;
                    n_state          = mea_pkg::S_EMIT;
                end else if (i_st.is_tri) begin
                    if (i_st.faulted) begin
                        o_cmd.set_ignored = 1'b1;
                        n_state           = mea_pkg::S_EMIT;
                    end else if (i_st.tri_full) begin
                        o_cmd.set_fault  = 1'b1;
                        o_cmd.fault_code = mea_pkg::ST_TOO_MANY;
                        n_state          = mea_pkg::S_EMIT;
                    end else begin
                        o_cmd.tri_begin = 1'b1;
                        n_state = i_st.skip ? mea_pkg::S_EMIT : mea_pkg::S_EDGE;
                    end
                end else begin
                    // drop unused kind without a result
                    n_state = mea_pkg::S_IDLE;
                end
            end
            mea_pkg::S_EDGE: begin
                o_cmd.hash_start = 1'b1;
                n_state          = mea_pkg::S_HASH;
            end
            mea_pkg::S_HASH: begin
                if (i_st.hash_done) begin
                    n_state = mea_pkg::S_READ;
                end
            end
            mea_pkg::S_READ: begin
                n_state = mea_pkg::S_CHECK;
            end
            mea_pkg::S_CHECK: begin
                if (i_st.rd_free || (i_st.rd_match && !i_st.rd_done)) begin
                    o_cmd.wr_new  = i_st.rd_free;
                    o_cmd.wr_pair = !i_st.rd_free;
                    if (i_st.edge_last) begin
                        n_state = mea_pkg::S_EMIT;
                    end else begin
                        o_cmd.edge_next = 1'b1;
                        n_state         = mea_pkg::S_EDGE;
                    end
                end else if (i_st.rd_match) begin
                    o_cmd.set_fault  = 1'b1;
                    o_cmd.fault_code = mea_pkg::ST_TRIPLE;
                    n_state          = mea_pkg::S_EMIT;
                end else if (i_st.probe_last) begin
                    o_cmd.set_fault  = 1'b1;
                    o_cmd.fault_code = mea_pkg::ST_FULL;
                    n_state          = mea_pkg::S_EMIT;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = mea_pkg::S_READ;
                end
            end
            mea_pkg::S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = mea_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mea_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/mea_dp.sv =====
// Datapath of the edge adjacency matcher: hash, edge table, counters, result register
module mea_dp #(
    parameter int MAX_TRIANGLES = 16384,
    parameter int EDGE_CAPACITY = 32768,
    parameter int VERTEX_BITS   = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mea_pkg::t_cmd               i_cmd,
    output mea_pkg::t_st                o_st,
    input  logic [mea_pkg::KIND_W-1:0]  i_kind,
    input  logic signed [mea_pkg::V0_W-1:0] i_v0,
    input  logic [mea_pkg::V_W-1:0]     i_v1,
    input  logic [mea_pkg::V_W-1:0]     i_v2,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [mea_pkg::TRI_W-1:0]   o_tri_index,
    output logic signed [mea_pkg::LINK_W-1:0] o_link0,
    output logic signed [mea_pkg::LINK_W-1:0] o_link1,
    output logic signed [mea_pkg::LINK_W-1:0] o_link2,
    output logic [mea_pkg::STATUS_W-1:0] o_status,
    output logic                        o_watertight,
    output logic [mea_pkg::OPEN_W-1:0]  o_open_edges
);

    localparam int  AW  = $clog2(EDGE_CAPACITY);
    localparam int  KW  = 2 * VERTEX_BITS;
    localparam int  LW  = mea_pkg::LINK_W;
    localparam int  WW  = 2 + LW + KW;
    localparam int  TCW = $clog2(MAX_TRIANGLES + 1);
    localparam int  OCW = $clog2(EDGE_CAPACITY + 1);
    localparam bit  CAP_POW2 = (EDGE_CAPACITY & (EDGE_CAPACITY - 1)) == 0;
    localparam logic [AW-1:0] IDX_LAST = AW'(EDGE_CAPACITY - 1);
    localparam logic [AW:0]   CAP_EXT  = (AW + 1)'(EDGE_CAPACITY);

    typedef enum logic [2:0] {
        H_IDLE,
        H_P1,
        H_P2,
        H_P3,
        H_MOD,
        H_DONE
    } t_hph;

    // Control state
    t_hph                          r_hph;
    logic [TCW-1:0]                r_tcount;
    logic [OCW-1:0]                r_open;
    logic [mea_pkg::STATUS_W-1:0]  r_fault;
    logic [AW-1:0]                 r_caddr;
    logic                          r_ovalid;

    // Item payload
    logic [mea_pkg::KIND_W-1:0]    r_kind;
    logic [VERTEX_BITS-1:0]        r_v [3];
    logic                          r_skip;
    logic [TCW-1:0]                r_tcur;
    logic [mea_pkg::TRI_W-1:0]     r_tri;
    logic [1:0]                    r_j;
    logic [LW-1:0]                 r_link [3];
    logic [mea_pkg::STATUS_W-1:0]  r_stat;

    // Hash and probe payload
    logic [63:0]                   r_prod;
    logic [mea_pkg::HASH_W-1:0]    r_acc;
    logic [AW-1:0]                 r_rem;
    logic [mea_pkg::HASH_CNT_W-1:0] r_mcnt;
    logic [AW-1:0]                 r_idx;
    logic [mea_pkg::PROBE_W-1:0]   r_probe;

    // Result register
    logic [mea_pkg::TRI_W-1:0]     r_o_tri;
    logic [LW-1:0]                 r_o_link [3];
    logic [mea_pkg::STATUS_W-1:0]  r_o_stat;
    logic                          r_o_wt;
    logic [mea_pkg::OPEN_W-1:0]    r_o_open;

    logic [VERTEX_BITS-1:0]        va, vb;
    logic [KW-1:0]                 cur_key;
    logic [63:0]                   key64;
    logic [31:0]                   mul_a, mul_b;
    logic [63:0]                   mul_p;
    logic [mea_pkg::HASH_W-1:0]    h_sum;
    logic [AW:0]                   rem2;
    logic [AW-1:0]                 rem_nx;
    logic [AW-1:0]                 idx_inc;
    logic [TCW+1:0]                slot_full;
    logic [LW-1:0]                 slot;
    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [WW-1:0]                 wdata, rdata;
    logic                          rd_used, rd_done;
    logic [LW-1:0]                 rd_slot;
    logic [KW-1:0]                 rd_key;
    logic                          wt;

    // Edge key: unordered vertex pair, smaller vertex in the upper half
    assign va      = r_v[mea_pkg::EDGE_ENDS[r_j][0]];
    assign vb      = r_v[mea_pkg::EDGE_ENDS[r_j][1]];
    assign cur_key = (va < vb) ? {va, vb} : {vb, va};
    assign key64   = 64'(cur_key);

    // Shared 32x32 multiplier for the partial products of key * HASH_MUL
    always_comb begin
        mul_a = key64[31:0];
        mul_b = mea_pkg::HASH_MUL[31:0];
        if (!i_cmd.hash_start) begin
            case (r_hph)
                H_P1: mul_b = mea_pkg::HASH_MUL[63:32];
                H_P2: mul_a = key64[63:32];
                default: ;
            endcase
        end
    end
    assign mul_p = mul_a * mul_b;

    assign h_sum   = r_acc + r_prod[31:0];
    assign rem2    = {r_rem, r_acc[mea_pkg::HASH_W-1]};
    assign rem_nx  = (rem2 >= CAP_EXT) ? AW'(rem2 - CAP_EXT) : AW'(rem2);
    assign idx_inc = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;

    // Hash phase sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hph <= H_IDLE;
        end else if (i_cmd.hash_start) begin
            r_hph <= H_P1;
        end else begin
            case (r_hph)
                H_P1:  r_hph <= H_P2;
                H_P2:  r_hph <= H_P3;
                H_P3:  r_hph <= CAP_POW2 ? H_DONE : H_MOD;
                H_MOD: begin
                    if (r_mcnt == {mea_pkg::HASH_CNT_W{1'b1}}) begin
                        r_hph <= H_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // Hash accumulate, remainder by capacity, probe index
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_cmd.hash_start) begin
            r_probe <= '0;
        end
        case (r_hph)
            H_P1: r_acc <= r_prod[63:32];
            H_P2: r_acc <= h_sum;
            H_P3: begin
                r_acc  <= h_sum;
                r_rem  <= '0;
                r_mcnt <= '0;
                r_idx  <= AW'(h_sum);
            end
            H_MOD: begin
                r_acc  <= r_acc << 1;
                r_rem  <= rem_nx;
                r_mcnt <= r_mcnt + 1'b1;
                r_idx  <= rem_nx;
            end
            default: ;
        endcase
        if (i_cmd.probe_next) begin
            r_idx   <= idx_inc;
            r_probe <= r_probe + 1'b1;
        end
    end

    // Edge table: {used, done, slot, key}
    assign slot_full = {r_tcur, r_j};
    assign slot      = LW'(slot_full);
    assign we        = i_cmd.clr_step | i_cmd.wr_new | i_cmd.wr_pair;
    assign waddr     = i_cmd.clr_step ? r_caddr : r_idx;
    always_comb begin
        wdata = '0;
        if (i_cmd.wr_new) begin
            wdata = {1'b1, 1'b0, slot, cur_key};
        end else if (i_cmd.wr_pair) begin
            wdata = {1'b1, 1'b1, rd_slot, rd_key};
        end
    end

    mea_ram #(
        .WIDTH (WW),
        .DEPTH (EDGE_CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign rd_used = rdata[WW-1];
    assign rd_done = rdata[WW-2];
    assign rd_slot = rdata[KW +: LW];
    assign rd_key  = rdata[KW-1:0];

    // Counters, fault, clear address, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcount <= '0;
            r_open   <= '0;
            r_fault  <= mea_pkg::ST_OK;
            r_caddr  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_caddr <= (r_caddr == IDX_LAST) ? '0 : r_caddr + 1'b1;
            end
            if (i_cmd.clr_counters) begin
                r_tcount <= '0;
                r_open   <= '0;
                r_fault  <= mea_pkg::ST_OK;
            end
            if (i_cmd.tri_begin) begin
                r_tcount <= r_tcount + 1'b1;
            end
            if (i_cmd.wr_new) begin
                r_open <= r_open + 1'b1;
            end
            if (i_cmd.wr_pair && (r_open != '0)) begin
                r_open <= r_open - 1'b1;
            end
            if (i_cmd.set_fault) begin
                r_fault <= i_cmd.fault_code;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Item capture and per-item result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_v[0]  <= VERTEX_BITS'(i_v0[mea_pkg::V_W-1:0]);
            r_v[1]  <= VERTEX_BITS'(i_v1);
            r_v[2]  <= VERTEX_BITS'(i_v2);
            r_skip  <= i_v0[mea_pkg::V0_W-1];
            r_tcur  <= r_tcount;
            r_tri   <= '0;
            if (i_kind == mea_pkg::KIND_TRI) begin
                r_tri <= (32'(r_tcount) > 32'(mea_pkg::TRI_SAT)) ? mea_pkg::TRI_SAT
                                                                 : mea_pkg::TRI_W'(r_tcount);
            end
            r_j     <= '0;
            r_stat  <= mea_pkg::ST_OK;
            for (int i = 0; i < 3; i++) begin
                r_link[i] <= mea_pkg::LINK_NONE;
            end
        end
        if (i_cmd.edge_next) begin
            r_j <= r_j + 1'b1;
        end
        if (i_cmd.wr_pair) begin
            r_link[r_j] <= rd_slot;
        end
        if (i_cmd.set_ignored) begin
            r_stat <= mea_pkg::ST_IGNORED;
        end
        if (i_cmd.finish_rep) begin
            r_stat <= r_fault;
        end
        if (i_cmd.set_fault) begin
            r_stat <= i_cmd.fault_code;
            for (int i = 0; i < 3; i++) begin
                r_link[i] <= mea_pkg::LINK_NONE;
            end
        end
    end

    // Result register
    assign wt = (r_kind == mea_pkg::KIND_FINISH) && (r_fault == mea_pkg::ST_OK)
                && (r_open == '0);
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_tri  <= r_tri;
            r_o_stat <= r_stat;
            r_o_wt   <= wt;
            r_o_open <= (32'(r_open) > 32'(mea_pkg::OPEN_SAT)) ? mea_pkg::OPEN_SAT
                                                              : mea_pkg::OPEN_W'(r_open);
            for (int i = 0; i < 3; i++) begin
                r_o_link[i] <= r_link[i];
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_tri_index  = r_o_tri;
    assign o_link0      = r_o_link[0];
    assign o_link1      = r_o_link[1];
    assign o_link2      = r_o_link[2];
    assign o_status     = r_o_stat;
    assign o_watertight = r_o_wt;
    assign o_open_edges = r_o_open;

    // Status toward the controller
    always_comb begin
        o_st            = '0;
        o_st.is_start   = (r_kind == mea_pkg::KIND_START);
        o_st.is_tri     = (r_kind == mea_pkg::KIND_TRI);
        o_st.is_finish  = (r_kind == mea_pkg::KIND_FINISH);
        o_st.faulted    = (r_fault != mea_pkg::ST_OK);
        o_st.tri_full   = (r_tcount >= TCW'(MAX_TRIANGLES));
        o_st.skip       = r_skip;
        o_st.clr_last   = (r_caddr == IDX_LAST);
        o_st.hash_done  = (r_hph == H_DONE);
        o_st.rd_free    = !rd_used;
        o_st.rd_match   = rd_used && (rd_key == cur_key);
        o_st.rd_done    = rd_done;
        o_st.probe_last = (r_probe == {mea_pkg::PROBE_W{1'b1}});
        o_st.edge_last  = (r_j == 2'd2);
        o_st.out_free   = !r_ovalid || i_out_ready;
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the triangle mesh edge adjacency matcher: directed and random requests
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_TRI    = 16384;
    localparam int EDGE_CAP   = 32768;
    localparam int VBITS      = 20;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int HOLD_CYCLES = 3000;
    localparam logic [mea_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic signed [mea_pkg::V0_W-1:0] V0_SKIP = -21'sd1;

    typedef struct {
        logic [mea_pkg::TRI_W-1:0]    tri_idx;
        logic [mea_pkg::LINK_W-1:0]   link [3];
        logic [mea_pkg::STATUS_W-1:0] status;
        logic                         watertight;
        logic [mea_pkg::OPEN_W-1:0]   open_edges;
    } t_adjacency;

    // Hash slot where the probe for an edge key starts
    function automatic int unsigned probe_base(logic [39:0] key);
        logic [63:0] prod;
        prod = {24'd0, key} * mea_pkg::HASH_MUL;
        return int'(prod[63:32] % EDGE_CAP);
    endfunction

    function automatic logic [39:0] edge_key(logic [19:0] a, logic [19:0] b);
        return (a < b) ? {a, b} : {b, a};
    endfunction

    // Mesh state mirror and queue of expected adjacency results
    class adjacency_board;
        logic [39:0]                  keys  [EDGE_CAP];
        logic [mea_pkg::LINK_W-1:0]   slots [EDGE_CAP];
        bit                           used  [EDGE_CAP];
        bit                           done  [EDGE_CAP];
        int unsigned                  tri_count;
        int unsigned                  open_count;
        logic [mea_pkg::STATUS_W-1:0] fault;
        t_adjacency                   pending_q [$];
        int                           mismatches;

        function new();
            mismatches = 0;
            clear_mesh();
        endfunction

        function void clear_mesh();
            foreach (used[i]) begin
                used[i] = 0;
                done[i] = 0;
            end
            tri_count = 0;
            open_count = 0;
            fault = mea_pkg::ST_OK;
        endfunction

        // Predict the result of one accepted request
        function void note_request(logic [mea_pkg::KIND_W-1:0] kind,
                                   logic signed [mea_pkg::V0_W-1:0] v0,
                                   logic [mea_pkg::V_W-1:0] v1, logic [mea_pkg::V_W-1:0] v2);
            t_adjacency  r;
            logic [19:0] v [3];
            logic [39:0] key;
            int unsigned base, pos, t;
            int          found;
            if (kind == KIND_UNUSED) return;
            r.tri_idx = '0;
            r.link = '{mea_pkg::LINK_NONE, mea_pkg::LINK_NONE, mea_pkg::LINK_NONE};
            r.status = mea_pkg::ST_OK;
            r.watertight = 0;
            if (kind == mea_pkg::KIND_START) begin
                clear_mesh();
            end else if (kind == mea_pkg::KIND_FINISH) begin
                r.status = fault;
                r.watertight = (fault == mea_pkg::ST_OK) && (open_count == 0);
            end else if (fault != mea_pkg::ST_OK) begin
                r.status = mea_pkg::ST_IGNORED;
                r.tri_idx = (tri_count > 16383) ? mea_pkg::TRI_SAT
                                                : tri_count[mea_pkg::TRI_W-1:0];
            end else if (tri_count >= MAX_TRI) begin
                fault = mea_pkg::ST_TOO_MANY;
                r.status = mea_pkg::ST_TOO_MANY;
                r.tri_idx = (tri_count > 16383) ? mea_pkg::TRI_SAT
                                                : tri_count[mea_pkg::TRI_W-1:0];
            end else begin
                t = tri_count;
                r.tri_idx = (t > 16383) ? mea_pkg::TRI_SAT : t[mea_pkg::TRI_W-1:0];
                tri_count = t + 1;
                if (!v0[mea_pkg::V0_W-1]) begin
                    v[0] = v0[19:0];
                    v[1] = v1;
                    v[2] = v2;
                    for (int j = 0; j < 3; j++) begin
                        key = edge_key(v[mea_pkg::EDGE_ENDS[j][0]], v[mea_pkg::EDGE_ENDS[j][1]]);
                        base = probe_base(key);
                        found = 2;
                        for (int p = 0; p < mea_pkg::PROBE_LIMIT; p++) begin
                            pos = (base + p) % EDGE_CAP;
                            if (!used[pos]) begin
                                found = 1;
                                break;
                            end
                            if (keys[pos] == key) begin
                                found = 0;
                                break;
                            end
                        end
                        if (found == 0) begin
                            if (done[pos]) begin
                                r.status = mea_pkg::ST_TRIPLE;
                                break;
                            end
                            r.link[j] = slots[pos];
                            done[pos] = 1;
                            if (open_count > 0) open_count--;
                        end else if (found == 1) begin
                            used[pos] = 1;
                            done[pos] = 0;
                            keys[pos] = key;
                            slots[pos] = mea_pkg::LINK_W'(4 * t + j);
                            open_count++;
                        end else begin
                            r.status = mea_pkg::ST_FULL;
                            break;
                        end
                    end
                    if (r.status != mea_pkg::ST_OK) begin
                        fault = r.status;
                        r.link = '{mea_pkg::LINK_NONE, mea_pkg::LINK_NONE,
                                   mea_pkg::LINK_NONE};
                    end
                end
            end
            r.open_edges = (open_count > 65535) ? mea_pkg::OPEN_SAT
                                                : open_count[mea_pkg::OPEN_W-1:0];
            pending_q.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(t_adjacency got);
            t_adjacency e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: tri %0d status %0d", got.tri_idx, got.status);
                return;
            end
            e = pending_q.pop_front();
            if (got.tri_idx != e.tri_idx || got.link[0] != e.link[0] ||
                got.link[1] != e.link[1] || got.link[2] != e.link[2] ||
                got.status != e.status || got.watertight != e.watertight ||
                got.open_edges != e.open_edges) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp tri %0d links %h %h %h st %0d wt %0d open %0d",
                             e.tri_idx, e.link[0], e.link[1], e.link[2], e.status,
                             e.watertight, e.open_edges);
                    $display("         got tri %0d links %h %h %h st %0d wt %0d open %0d",
                             got.tri_idx, got.link[0], got.link[1], got.link[2],
                             got.status, got.watertight, got.open_edges);
                end
            end
        endfunction
    endclass

    logic                                i_clk = 0;
    logic                                i_rst_n = 0;
    logic                                i_in_valid = 0;
    logic                                o_in_ready;
    logic [mea_pkg::KIND_W-1:0]          i_kind = mea_pkg::KIND_START;
    logic signed [mea_pkg::V0_W-1:0]     i_v0 = '0;
    logic [mea_pkg::V_W-1:0]             i_v1 = '0;
    logic [mea_pkg::V_W-1:0]             i_v2 = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 0;
    logic [mea_pkg::TRI_W-1:0]           o_tri_index;
    logic signed [mea_pkg::LINK_W-1:0]   o_link0, o_link1, o_link2;
    logic [mea_pkg::STATUS_W-1:0]        o_status;
    logic                                o_watertight;
    logic [mea_pkg::OPEN_W-1:0]          o_open_edges;

    adjacency_board board = new();
    int  cycles = 0;
    bit  hold_pending = 0;

    mesh_edge_adjacency_matcher uut (.*);

    always #6 i_clk = ~i_clk;

    // Note accepted requests, check accepted results, bound the run
    always @(posedge i_clk) begin
        t_adjacency got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && i_in_valid && o_in_ready)
            board.note_request(i_kind, i_v0, i_v1, i_v2);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.tri_idx = o_tri_index;
            got.link = '{o_link0, o_link1, o_link2};
            got.status = o_status;
            got.watertight = o_watertight;
            got.open_edges = o_open_edges;
            board.check_result(got);
        end
    end

    // Drive result ready: random stalls, bursts of long stalls, one long hold-off
    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                i_out_ready <= 0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_pending = 0;
            end else if ($urandom_range(0, 3) != 0) begin
                i_out_ready <= 1;
            end else if ($urandom_range(0, 49) == 0) begin
                stall = $urandom_range(10, 60);
                i_out_ready <= 0;
                repeat (stall) @(posedge i_clk);
            end else begin
                i_out_ready <= 0;
            end
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(1, 4);
    endfunction

    // Offer one request and hold it until accepted
    task automatic send(logic [mea_pkg::KIND_W-1:0] kind, logic signed [mea_pkg::V0_W-1:0] v0,
                        logic [mea_pkg::V_W-1:0] v1, logic [mea_pkg::V_W-1:0] v2);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_kind <= kind;
        i_v0 <= v0;
        i_v1 <= v1;
        i_v2 <= v2;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_tri(logic [19:0] a, logic [19:0] b, logic [19:0] c);
        send(mea_pkg::KIND_TRI, {1'b0, a}, b, c);
    endtask

    function automatic logic [19:0] rand_vertex();
        return 20'($urandom_range(0, 20'hFFFFF));
    endfunction

    // Closed tetrahedra with fresh labels, noise triangles and side requests
    task automatic run_mesh_segment(int n_items, bit noisy, bit add_triple);
        int unsigned faces [4][3] = '{'{0, 1, 2}, '{0, 3, 1}, '{0, 2, 3}, '{1, 3, 2}};
        int          ord [4];
        logic [19:0] lab [4], a, b, c;
        int          cnt, r, k, tmp, dup_at;
        cnt = 0;
        dup_at = add_triple ? $urandom_range(n_items / 2, n_items - 10) : -1;
        send(mea_pkg::KIND_START, '0, '0, '0);
        while (cnt < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 80 || !noisy && r < 88) begin
                foreach (lab[i]) lab[i] = rand_vertex();
                ord = '{0, 1, 2, 3};
                for (int i = 3; i > 0; i--) begin
                    k = $urandom_range(0, i);
                    tmp = ord[i];
                    ord[i] = ord[k];
                    ord[k] = tmp;
                end
                foreach (ord[i]) begin
                    a = lab[faces[ord[i]][0]];
                    b = lab[faces[ord[i]][1]];
                    c = lab[faces[ord[i]][2]];
                    send_tri(a, b, c);
                    if (cnt >= dup_at && dup_at >= 0) begin
                        send_tri(b, c, a);
                        dup_at = -1;
                    end
                end
                cnt += 4;
            end else if (r < 88) begin
                send_tri(rand_vertex(), rand_vertex(), rand_vertex());
                cnt++;
            end else if (r < 93) begin
                send(mea_pkg::KIND_TRI, {1'b1, rand_vertex()}, rand_vertex(), rand_vertex());
                cnt++;
            end else if (r < 98) begin
                send(mea_pkg::KIND_FINISH, 21'($urandom()), 20'($urandom()), 20'($urandom()));
                cnt++;
            end else begin
                send(KIND_UNUSED, 21'($urandom()), 20'($urandom()), 20'($urandom()));
            end
        end
        send(mea_pkg::KIND_FINISH, '0, '0, '0);
    endtask

    // Crowd one probe window until a new edge finds no free entry
    task automatic run_table_full();
        logic [19:0] a, b;
        int unsigned win;
        win = $urandom_range(0, EDGE_CAP - 1);
        send(mea_pkg::KIND_START, '0, '0, '0);
        repeat (45) begin
            do begin
                a = rand_vertex();
                b = rand_vertex();
            end while (a == b || ((probe_base(edge_key(a, b)) - win) % EDGE_CAP) >= 4);
            send_tri(a, b, rand_vertex());
        end
        send_tri(20'd1, 20'd2, 20'd3);
        send(mea_pkg::KIND_FINISH, '0, '0, '0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: empty mesh, unused kind, extremes, skip, pairing, triple edge
        send(mea_pkg::KIND_FINISH, '0, '0, '0);
        send(KIND_UNUSED, '0, '0, '0);
        send_tri(20'd1, 20'd2, 20'd3);
        send_tri(20'd3, 20'd2, 20'd1);
        send(mea_pkg::KIND_FINISH, '0, '0, '0);
        send_tri(20'hFFFFF, 20'd0, 20'h80000);
        send(mea_pkg::KIND_TRI, V0_SKIP, 20'hFFFFF, 20'hFFFFF);
        send(mea_pkg::KIND_FINISH, '0, '0, '0);
        send_tri(20'd0, 20'h80000, 20'hFFFFF);
        send(mea_pkg::KIND_FINISH, '0, '0, '0);
        send_tri(20'd5, 20'd5, 20'd5);
        send_tri(20'd7, 20'd8, 20'd9);
        send(mea_pkg::KIND_FINISH, '0, '0, '0);
        send(mea_pkg::KIND_START, '0, '0, '0);
        send_tri(20'd7, 20'd8, 20'd9);
        send(KIND_UNUSED, 21'h1FFFFF, 20'hFFFFF, 20'hFFFFF);
        send(mea_pkg::KIND_FINISH, '0, '0, '0);

        // Random: one clean segment, noisy ones, one with a triple edge, then a full probe window
        hold_pending = 1;
        run_mesh_segment(460, 0, 0);
        run_mesh_segment(460, 1, 0);
        run_mesh_segment(460, 1, 1);
        run_mesh_segment(460, 1, 0);
        run_table_full();
        i_in_valid <= 0;

        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
